>>> rtl/rrts_pkg.sv
// Shared types and codes of the round-robin task scheduler.
`timescale 1ns / 1ps
package rrts_pkg;

  // Request kinds carried on the input tuser field.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SCHED = 2'd1,
    OP_EXIT  = 2'd2
  } op_e;

  // Per-slot task status.
  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_ZOMBIE  = 2'd3
  } task_st_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEMOTE,
    S_SCAN,
    S_FETCH,
    S_LOAD,
    S_DONE
  } seq_st_e;

  // Write enables toward the task table.
  typedef struct packed {
    logic st_we;
    logic sp_we;
    logic ks_we;
  } tbl_we_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [31:0] resume_stack_pointer;
    logic [7:0]  running_task_id;
    logic [31:0] kernel_stack_top_out;
    logic        load_kernel_stack;
    logic [7:0]  new_task_id;
    logic        status;
  } res_t;

  localparam int unsigned SpW      = 32;
  localparam int unsigned OutDataW = 88;

endpackage

>>> rtl/rrts_table.sv
// Task table: status, saved stack pointer and kernel stack top memories.
`timescale 1ns / 1ps
module rrts_table
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tbl_we_t                      we_i,
  input  logic [$clog2(MAX_TASKS)-1:0] wr_addr_i,
  input  task_st_e                     st_wdata_i,
  input  logic [SpW-1:0]               sp_wdata_i,
  input  logic [SpW-1:0]               ks_wdata_i,
  input  logic [$clog2(MAX_TASKS)-1:0] rd_addr_i,
  output task_st_e                     st_rdata_o,
  output logic [SpW-1:0]               sp_rdata_o,
  output logic [SpW-1:0]               ks_rdata_o
);

  localparam int unsigned SW = $clog2(MAX_TASKS);

  task_st_e       st_mem [MAX_TASKS];
  logic [SpW-1:0] sp_mem [MAX_TASKS];
  logic [SpW-1:0] ks_mem [MAX_TASKS];

  task_st_e       st_rd_q;
  logic [SW-1:0]  rd_addr_q;
  logic           s0_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i.st_we) begin
      st_mem[wr_addr_i] <= st_wdata_i;
    end
    if (we_i.sp_we) begin
      sp_mem[wr_addr_i] <= sp_wdata_i;
    end
    if (we_i.ks_we) begin
      ks_mem[wr_addr_i] <= ks_wdata_i;
    end
    st_rd_q    <= st_mem[rd_addr_i];
    sp_rdata_o <= sp_mem[rd_addr_i];
    ks_rdata_o <= ks_mem[rd_addr_i];
    rd_addr_q  <= rd_addr_i;
  end

  // Kernel slot reads as running until its status is first written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (we_i.st_we && (wr_addr_i == '0)) begin
      s0_vld_q <= 1'b1;
    end
  end

  assign st_rdata_o = (rd_addr_q == '0 && !s0_vld_q) ? ST_RUNNING : st_rd_q;

endmodule

>>> rtl/rrts_ctrl.sv
// Request sequencer with the shared slot-successor and status-compare unit.
`timescale 1ns / 1ps
module rrts_ctrl
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  op_e                          req_op_i,
  input  logic [SpW-1:0]               req_sp_i,
  input  logic [SpW-1:0]               req_ks_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output res_t                         res_o,
  output tbl_we_t                      we_o,
  output logic [$clog2(MAX_TASKS)-1:0] wr_addr_o,
  output task_st_e                     st_wdata_o,
  output logic [SpW-1:0]               sp_wdata_o,
  output logic [SpW-1:0]               ks_wdata_o,
  output logic [$clog2(MAX_TASKS)-1:0] rd_addr_o,
  input  task_st_e                     st_rdata_i,
  input  logic [SpW-1:0]               sp_rdata_i,
  input  logic [SpW-1:0]               ks_rdata_i
);

  localparam int unsigned SW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  seq_st_e        state_q, state_d;
  op_e            op_q, op_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic [SpW-1:0] ks_q, ks_d;
  logic [SW-1:0]  cur_q, cur_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [SW-1:0]  ptr_q, ptr_d;
  logic [CW-1:0]  iss_q, iss_d;
  logic [SW-1:0]  cand_q, cand_d;
  logic           cand_vld_q, cand_vld_d;
  logic [SW-1:0]  nx_q, nx_d;
  res_t           res_q, res_d;

  // Shared unit: successor of a slot within the used range, and the ready-or-running test.
  logic [SW-1:0]  succ_in;
  logic [SW-1:0]  succ_out;
  logic           st_hit;

  assign succ_in  = (state_q == S_DEMOTE) ? cur_q : ptr_q;
  assign succ_out = (CW'(succ_in) == cnt_q - CW'(1)) ? '0 : succ_in + SW'(1);
  assign st_hit   = (st_rdata_i == ST_READY) || (st_rdata_i == ST_RUNNING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_q      <= '0;
      cnt_q      <= CW'(1);
      iss_q      <= '0;
      cand_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      cnt_q      <= cnt_d;
      iss_q      <= iss_d;
      cand_vld_q <= cand_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    sp_q   <= sp_d;
    ks_q   <= ks_d;
    ptr_q  <= ptr_d;
    cand_q <= cand_d;
    nx_q   <= nx_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sp_d        = sp_q;
    ks_d        = ks_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    iss_d       = iss_q;
    cand_d      = cand_q;
    cand_vld_d  = cand_vld_q;
    nx_d        = nx_q;
    res_d       = res_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    we_o        = '0;
    wr_addr_o   = cur_q;
    st_wdata_o  = ST_READY;
    sp_wdata_o  = sp_q;
    ks_wdata_o  = ks_q;
    rd_addr_o   = cur_q;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d    = req_op_i;
          sp_d    = req_sp_i;
          ks_d    = req_ks_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '0;
        state_d = S_DONE;
        case (op_q)
          OP_ADD: begin
            if (cnt_q == CW'(MAX_TASKS)) begin
              res_d.status = 1'b1;
            end else begin
              we_o              = '{st_we: 1'b1, sp_we: 1'b1, ks_we: 1'b1};
              wr_addr_o         = cnt_q[SW-1:0];
              st_wdata_o        = ST_READY;
              res_d.new_task_id = 8'(cnt_q);
              cnt_d             = cnt_q + CW'(1);
            end
          end
          OP_SCHED: begin
            // save caller stack pointer, fetch current status
            we_o.sp_we = 1'b1;
            rd_addr_o  = cur_q;
            state_d    = S_DEMOTE;
          end
          OP_EXIT: begin
            we_o.st_we = 1'b1;
            st_wdata_o = ST_ZOMBIE;
          end
          default: ;
        endcase
      end
      S_DEMOTE: begin
        if (st_rdata_i == ST_RUNNING) begin
          we_o.st_we = 1'b1;
          st_wdata_o = ST_READY;
        end
        ptr_d      = succ_out;
        iss_d      = '0;
        cand_vld_d = 1'b0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        // one read issued per cycle, checked the cycle after
        rd_addr_o = ptr_q;
        if (cand_vld_q && st_hit) begin
          nx_d    = cand_q;
          state_d = S_FETCH;
        end else if (iss_q == cnt_q) begin
          nx_d    = cur_q;
          state_d = S_FETCH;
        end else begin
          cand_d     = ptr_q;
          cand_vld_d = 1'b1;
          ptr_d      = succ_out;
          iss_d      = iss_q + CW'(1);
        end
      end
      S_FETCH: begin
        rd_addr_o  = nx_q;
        wr_addr_o  = nx_q;
        we_o.st_we = 1'b1;
        st_wdata_o = ST_RUNNING;
        cur_d      = nx_q;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        res_d.resume_stack_pointer = sp_rdata_i;
        if (cur_q != '0) begin
          res_d.load_kernel_stack    = 1'b1;
          res_d.kernel_stack_top_out = ks_rdata_i;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o                 = res_q;
    res_o.running_task_id = 8'(cur_q);
  end

endmodule

>>> rtl/round_robin_task_scheduler_core.sv
// Top level of the round-robin task scheduler: stream ports, output register, checks.
// Sequence: add, exit and reserved requests pass through the execute and done states;
//   a schedule request adds demote, scan, fetch and load, its worst case growing with n =
//   slots in use, set by the one-slot-per-cycle status scan through the single table read port.
// Throughput: one request at a time; input ready only while the sequencer is idle,
//   a finished result waits in the output register while the next request is taken.
// Reset: asynchronous, active low; slot 0 running, one slot in use, stack memories
//   undefined until written, no clearing pass.
`timescale 1ns / 1ps
module round_robin_task_scheduler_core
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [63:0]         s_axis_tdata_i,  // [31:0] stack_pointer, [63:32] kernel_stack_top_in
  input  logic [1:0]          s_axis_tuser_i,  // [1:0] operation
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [31:0] resume_stack_pointer, [39:32] running_task_id, [71:40] kernel_stack_top_out,
  // [72] load_kernel_stack, [80:73] new_task_id, [81] status, [87:82] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned SW = $clog2(MAX_TASKS);

  tbl_we_t        tbl_we;
  logic [SW-1:0]  tbl_wr_addr;
  logic [SW-1:0]  tbl_rd_addr;
  task_st_e       tbl_st_wdata;
  task_st_e       tbl_st_rdata;
  logic [SpW-1:0] tbl_sp_wdata;
  logic [SpW-1:0] tbl_ks_wdata;
  logic [SpW-1:0] tbl_sp_rdata;
  logic [SpW-1:0] tbl_ks_rdata;

  logic           res_valid;
  logic           res_ready;
  res_t           res;

  // output register
  logic           m_valid_q;
  res_t           m_res_q;

  rrts_ctrl #(
    .MAX_TASKS(MAX_TASKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(s_axis_tvalid_i),
    .req_ready_o(s_axis_tready_o),
    .req_op_i   (op_e'(s_axis_tuser_i)),
    .req_sp_i   (s_axis_tdata_i[31:0]),
    .req_ks_i   (s_axis_tdata_i[63:32]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .we_o       (tbl_we),
    .wr_addr_o  (tbl_wr_addr),
    .st_wdata_o (tbl_st_wdata),
    .sp_wdata_o (tbl_sp_wdata),
    .ks_wdata_o (tbl_ks_wdata),
    .rd_addr_o  (tbl_rd_addr),
    .st_rdata_i (tbl_st_rdata),
    .sp_rdata_i (tbl_sp_rdata),
    .ks_rdata_i (tbl_ks_rdata)
  );

  rrts_table #(
    .MAX_TASKS(MAX_TASKS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (tbl_we),
    .wr_addr_i (tbl_wr_addr),
    .st_wdata_i(tbl_st_wdata),
    .sp_wdata_i(tbl_sp_wdata),
    .ks_wdata_i(tbl_ks_wdata),
    .rd_addr_i (tbl_rd_addr),
    .st_rdata_o(tbl_st_rdata),
    .sp_rdata_o(tbl_sp_rdata),
    .ks_rdata_o(tbl_ks_rdata)
  );

  // Result slot frees when empty or when the sink takes it this cycle.
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'd0,
                            m_res_q.status,
                            m_res_q.new_task_id,
                            m_res_q.load_kernel_stack,
                            m_res_q.kernel_stack_top_out,
                            m_res_q.running_task_id,
                            m_res_q.resume_stack_pointer};

  // Sequencer is busy right after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("scheduler took a request while still busy");

  // Running slot stays inside the table.
  a_running_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_res_q.running_task_id < 8'(MAX_TASKS - 1) ||
                         m_res_q.running_task_id == 8'(MAX_TASKS - 1)))
    else $error("running task id beyond table");

  // A kernel stack load never goes with the kernel slot.
  a_load_not_kernel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_res_q.load_kernel_stack |-> m_res_q.running_task_id != 8'd0)
    else $error("kernel stack load flagged for kernel slot");

  // A refused add reports no slot and no resume.
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_res_q.status |->
      m_res_q.new_task_id == 8'd0 && !m_res_q.load_kernel_stack &&
      m_res_q.resume_stack_pointer == 32'd0)
    else $error("refused add carries data");

endmodule

>>> sim/round_robin_task_scheduler_core_tb.sv
// Self-checking testbench of the round-robin task scheduler core.
`timescale 1ns / 1ps
module round_robin_task_scheduler_core_tb;
  import rrts_pkg::*;

  localparam int unsigned NumSlots    = 16;
  localparam int unsigned QuietLimit  = 2000;  // cycles with no request or result moving
  localparam int unsigned DrainCycles = 40;    // outlasts the longest schedule request
  localparam logic [1:0]  OpReserved  = 2'd3;  // unused code: no state change

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [63:0]         s_axis_tdata_i  = '0;  // [31:0] stack_pointer, [63:32] kernel_stack_top_in
  logic [1:0]          s_axis_tuser_i  = '0;  // [1:0] operation
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [31:0] resume_stack_pointer, [39:32] running_task_id, [71:40] kernel_stack_top_out,
  // [72] load_kernel_stack, [80:73] new_task_id, [81] status, [87:82] zero
  logic [OutDataW-1:0] m_axis_tdata_o;

  round_robin_task_scheduler_core #(
    .MAX_TASKS(NumSlots)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  // Scheduler shadow state
  task_st_e    slot_status [NumSlots];
  logic [31:0] slot_sp     [NumSlots];
  logic [31:0] slot_kst    [NumSlots];
  int unsigned cur_slot;
  int unsigned slot_count;

  res_t        pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned src_gap_pct    = 30;
  int unsigned sink_stall_pct = 63;
  int unsigned quiet_cycles   = 0;

  // First ready or running slot after the current one, wrapping back onto it.
  function automatic int unsigned next_ready_slot();
    int unsigned s;
    for (int unsigned i = 1; i <= slot_count; i++) begin
      s = (cur_slot + i) % slot_count;
      if (slot_status[s] == ST_READY || slot_status[s] == ST_RUNNING) return s;
    end
    return cur_slot;
  endfunction

  // Applies one request to the shadow state and returns the result it should produce.
  function automatic res_t schedule_outcome(logic [1:0] op, logic [31:0] sp, logic [31:0] kst);
    res_t        r;
    int unsigned nxt;
    r = '0;
    case (op)
      OP_ADD: begin
        if (slot_count >= NumSlots) begin
          r.status = 1'b1;  // table full, nothing changes
        end else begin
          slot_status[slot_count] = ST_READY;
          slot_sp[slot_count]     = sp;
          slot_kst[slot_count]    = kst;
          r.new_task_id           = 8'(slot_count);
          slot_count++;
        end
      end
      OP_SCHED: begin
        slot_sp[cur_slot] = sp;
        // a zombie stays a zombie; only a running task is demoted
        if (slot_status[cur_slot] == ST_RUNNING) slot_status[cur_slot] = ST_READY;
        nxt                  = next_ready_slot();
        cur_slot             = nxt;
        slot_status[nxt]     = ST_RUNNING;
        if (nxt != 0) begin
          r.load_kernel_stack    = 1'b1;
          r.kernel_stack_top_out = slot_kst[nxt];
        end
        r.resume_stack_pointer = slot_sp[nxt];
      end
      OP_EXIT: slot_status[cur_slot] = ST_ZOMBIE;
      default: ;
    endcase
    r.running_task_id = 8'(cur_slot);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) report_mismatch(name, want, got);
  endtask

  function automatic logic [31:0] random_word();
    int unsigned k;
    k = $urandom_range(0, 7);
    if (k == 0) return '0;
    if (k == 1) return '1;
    return $urandom;
  endfunction

  // Drives one request at the falling edge, holds it until accepted, then predicts it.
  task automatic send_request(logic [1:0] op, logic [31:0] sp, logic [31:0] kst);
    res_t want;
    while ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {kst, sp};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = schedule_outcome(op, sp, kst);
    pending_results.push_back(want);
    @(negedge clk_i);
  endtask

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Result checker: each accepted result against the oldest prediction
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", '0, m_axis_tdata_o[31:0]);
      end else begin
        want = pending_results.pop_front();
        check_field("resume_stack_pointer", want.resume_stack_pointer, m_axis_tdata_o[31:0]);
        check_field("running_task_id", 32'(want.running_task_id), 32'(m_axis_tdata_o[39:32]));
        check_field("kernel_stack_top_out", want.kernel_stack_top_out, m_axis_tdata_o[71:40]);
        check_field("load_kernel_stack", 32'(want.load_kernel_stack), 32'(m_axis_tdata_o[72]));
        check_field("new_task_id", 32'(want.new_task_id), 32'(m_axis_tdata_o[80:73]));
        check_field("status", 32'(want.status), 32'(m_axis_tdata_o[81]));
        check_field("padding", '0, 32'(m_axis_tdata_o[87:82]));
      end
    end
  end

  // Watchdog on a stalled handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("** round_robin_task_scheduler_core: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_reserved_op();
    send_request(OpReserved, '1, '1);
    send_request(OpReserved, '0, '0);
  endtask

  // Only the kernel exists: it is picked again and gets its own stack pointer back.
  task automatic test_kernel_alone();
    send_request(OP_SCHED, '0, '1);
    send_request(OP_SCHED, '1, '0);
  endtask

  // Kernel exits and nothing else is ready: it is kept and marked running again.
  task automatic test_kernel_exit();
    send_request(OP_EXIT, 32'h0bad_f00d, 32'h1357_9bdf);
    send_request(OP_SCHED, 32'h1234_5678, 32'h8765_4321);
  endtask

  task automatic test_add_extremes();
    send_request(OP_ADD, '0, '0);
    send_request(OP_ADD, '1, '1);
  endtask

  // Round-robin over kernel and two tasks, with and without kernel stack load.
  task automatic test_rotation();
    send_request(OP_SCHED, 32'ha5a5_a5a5, 32'h0);
    send_request(OP_SCHED, 32'h5a5a_5a5a, 32'h0);
    send_request(OP_SCHED, 32'hdead_beef, 32'h0);
    send_request(OP_SCHED, 32'hcafe_0001, 32'h0);
  endtask

  // A task that exits is saved but skipped from then on.
  task automatic test_task_exit();
    send_request(OP_EXIT, 32'h0, 32'h0);
    send_request(OP_SCHED, 32'h1111_2222, 32'h0);
    send_request(OP_SCHED, 32'h3333_4444, 32'h0);
    send_request(OP_SCHED, 32'h5555_6666, 32'h0);
    send_request(OpReserved, 32'h7777_8888, 32'h9999_aaaa);
  endtask

  // Mostly schedule ticks; adds fill the table and then get refused; exits are rare.
  task automatic test_random_traffic(int unsigned count, int unsigned gap_pct,
                                     int unsigned stall_pct);
    int unsigned pick;
    logic [1:0]  op;
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 18)      op = OP_ADD;
      else if (pick < 92) op = OP_SCHED;
      else if (pick < 95) op = OP_EXIT;
      else                op = OpReserved;
      send_request(op, random_word(), random_word());
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < NumSlots; i++) begin
      slot_status[i] = ST_UNUSED;
      slot_sp[i]     = '0;
      slot_kst[i]    = '0;
    end
    slot_status[0] = ST_RUNNING;
    cur_slot       = 0;
    slot_count     = 1;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reserved_op();
    test_kernel_alone();
    test_kernel_exit();
    test_add_extremes();
    test_rotation();
    test_task_exit();
    test_random_traffic(200, 30, 63);
    test_random_traffic(200, 63, 30);
    test_random_traffic(200, 0, 0);

    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("** round_robin_task_scheduler_core: PASSED **");
    end else begin
      $display("** round_robin_task_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule
